[design/assert_macros.svh]
// Assertion helpers, included by wall_follow_steering_unit.
// Every check is sampled on clk_i and switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge.
`define WFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition is never seen.
`define WFS_ASSERT_NEVER(lbl, cond, msg) \
  `WFS_ASSERT(lbl, !(cond), msg)

`endif

[design/wfs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfs_pkg
// Types, constants and the front range table of the wall follow steering unit.
// ----------------------------------------------------------------------------
package wfs_pkg;

  // Sample and field widths
  localparam int unsigned SAMPLE_BITS = 10;
  localparam int unsigned IN_DATA_W   = ((4 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned SPEED_W     = 11;
  localparam int unsigned THR_W       = 10;
  localparam int unsigned DIVR_W      = 10;
  localparam int unsigned DRIVE_W     = 12;
  localparam int unsigned OUT_DATA_W  = 2 * DRIVE_W;
  // Internal drives and targets, one bit wider than the port drives
  localparam int unsigned TGT_W       = 13;
  localparam int unsigned RANGE_W     = 9;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SPEED    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_SPEED    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_THRESH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_THRESH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEER_DIVIDER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_LEFT     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_RIGHT    = 3'd6;

  // Register reset values
  localparam logic [SPEED_W-1:0] RST_FULL_SPEED    = 11'd1024;
  localparam logic [SPEED_W-1:0] RST_SLOW_SPEED    = 11'd500;
  localparam logic [THR_W-1:0]   RST_SLOW_THRESH   = 10'd375;
  localparam logic [THR_W-1:0]   RST_STOP_THRESH   = 10'd450;
  localparam logic [DIVR_W-1:0]  RST_STEER_DIVIDER = 10'd150;
  localparam logic [DRIVE_W-1:0] RST_STOP_LEFT     = 12'hF38; // -200
  localparam logic [DRIVE_W-1:0] RST_STOP_RIGHT    = 12'hC18; // -1000
  localparam logic [TGT_W-1:0]   RST_PREV_DRIVE    = 13'd1024;

  // Shared multiply / divide unit
  localparam int unsigned OPA_W     = 20;
  localparam int unsigned OPB_W     = 21;
  localparam int unsigned PROD_W    = OPA_W + OPB_W;
  localparam int unsigned DIV_STEPS = OPA_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  // Reciprocals: n/1000 for n < 2^19 and n/10 for n < 2^12 are exact this way
  localparam logic [OPB_W-1:0] RECIP_1000       = 21'd1073742;
  localparam int unsigned      RECIP_1000_SHIFT = 30;
  localparam logic [OPB_W-1:0] RECIP_10         = 21'd6554;
  localparam int unsigned      RECIP_10_SHIFT   = 16;
  localparam int unsigned      SMOOTH_STEP_W    = 9;

  typedef enum logic [0:0] {
    MDU_MUL,
    MDU_DIV
  } mdu_op_e;

  typedef struct packed {
    logic             start;
    mdu_op_e          op;
    logic [OPA_W-1:0] a;
    logic [OPB_W-1:0] b;
  } mdu_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] result;
  } mdu_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RNG_MUL,
    ST_RNG_SUB,
    ST_RNG_REC,
    ST_RNG_CAP,
    ST_STR_MUL,
    ST_STR_DIV,
    ST_STR_WAIT,
    ST_SML_MUL,
    ST_SML_CAP,
    ST_SMR_MUL,
    ST_SMR_CAP,
    ST_OUT
  } wfs_state_e;

  // One segment of the front range table: range = (icpt - slope * u) / 1000
  localparam int unsigned SLOPE_W = 11;
  localparam int unsigned ICPT_W  = 19;

  typedef struct packed {
    logic [SLOPE_W-1:0] slope;
    logic [ICPT_W-1:0]  icpt;
  } seg_t;

  function automatic seg_t front_seg(input logic [SAMPLE_BITS-1:0] u);
    seg_t s;
    if (u < SAMPLE_BITS'(100)) begin
      s.slope = 11'd0;
      s.icpt  = 19'd300000;
    end else if (u < SAMPLE_BITS'(164)) begin
      s.slope = 11'd1041;
      s.icpt  = 19'd330591;
    end else if (u < SAMPLE_BITS'(481)) begin
      s.slope = 11'd347;
      s.icpt  = 19'd216775;
    end else if (u < SAMPLE_BITS'(614)) begin
      s.slope = 11'd112;
      s.icpt  = 19'd104231;
    end else begin
      s.slope = 11'd0;
      s.icpt  = 19'd35000;
    end
    return s;
  endfunction

endpackage

[design/wfs_mdu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfs_mdu
// Shared multiply / divide unit: registered multiply, restoring divide with
// one quotient bit per cycle. Result and done follow the request.
// ----------------------------------------------------------------------------
module wfs_mdu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wfs_pkg::mdu_req_t req_i,
  output wfs_pkg::mdu_rsp_t rsp_o
);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [wfs_pkg::CNT_W-1:0]       cnt_q, cnt_d;
  logic [wfs_pkg::DIVR_W-1:0]      rem_q, rem_d;
  logic [wfs_pkg::DIVR_W-1:0]      dvs_q, dvs_d;
  logic [wfs_pkg::PROD_W-1:0]      res_q, res_d;
  logic [wfs_pkg::DIVR_W:0]        trial;
  logic                            fits;
  logic                            last_step;

  // One restoring step: bring down the next dividend bit, subtract if it fits
  assign trial     = {rem_q, res_q[wfs_pkg::OPA_W-1]};
  assign fits      = trial >= {1'b0, dvs_q};
  assign last_step = cnt_q == wfs_pkg::CNT_W'(wfs_pkg::DIV_STEPS - 1);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    res_d  = res_q;
    if (busy_q) begin
      rem_d = fits ? wfs_pkg::DIVR_W'(trial - {1'b0, dvs_q}) : trial[wfs_pkg::DIVR_W-1:0];
      res_d = {{wfs_pkg::OPB_W{1'b0}}, res_q[wfs_pkg::OPA_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (last_step) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      case (req_i.op)
        wfs_pkg::MDU_MUL: begin
          res_d  = wfs_pkg::PROD_W'(req_i.a) * wfs_pkg::PROD_W'(req_i.b);
          done_d = 1'b1;
        end
        wfs_pkg::MDU_DIV: begin
          res_d  = wfs_pkg::PROD_W'(req_i.a);
          dvs_d  = req_i.b[wfs_pkg::DIVR_W-1:0];
          rem_d  = '0;
          cnt_d  = '0;
          busy_d = 1'b1;
        end
        default: begin
          done_d = 1'b0;
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operands and partial results
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    res_q <= res_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

endmodule

[design/wall_follow_steering_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wall_follow_steering_unit
// Turns one set of four distance samples into left and right wheel drives.
// ----------------------------------------------------------------------------
// Once a word is accepted, s_axis_tready stays low until its drive word is
// loaded into the output register, so a new word is taken only after the last
// one is through. In between come two front range lookups through the shared
// multiplier (slope multiply, subtraction from the intercept, reciprocal
// multiply, capture), the steering multiply, the start of the divider, a
// restoring division by steer_divider, the capture of the quotient, two
// smoothing steps and one output load. The finished word waits in an output
// register, so the next word is taken while it is still unread; the block
// stalls only when a second result is ready before the first has gone.
// Configuration writes are always taken and must only happen while idle.
module wall_follow_steering_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Sample words
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // left_front_sample, right_front_sample, left_side_sample, right_side_sample
  input  logic [wfs_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // Drive words
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // left_drive, right_drive
  output logic [wfs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // Register writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [wfs_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [wfs_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

`include "assert_macros.svh"

  localparam int unsigned SB = wfs_pkg::SAMPLE_BITS;

  // Configuration registers
  logic [wfs_pkg::SPEED_W-1:0] full_speed_q, slow_speed_q;
  logic [wfs_pkg::THR_W-1:0]   slow_thr_q, stop_thr_q;
  logic [wfs_pkg::DIVR_W-1:0]  steer_div_q;
  logic [wfs_pkg::DRIVE_W-1:0] stop_left_q, stop_right_q;

  // Sequencer and working registers
  wfs_pkg::wfs_state_e         state_q, state_d;
  logic                        side_q;
  logic [SB-1:0]               lf_q, rf_q;
  logic                        stop_q;
  logic [wfs_pkg::SPEED_W-1:0] v_q;
  logic [wfs_pkg::OPA_W-1:0]   num_q;
  logic [wfs_pkg::RANGE_W-1:0] rl_q, rr_q;
  logic signed [wfs_pkg::TGT_W-1:0] tgt_l_q, tgt_r_q;
  logic signed [wfs_pkg::TGT_W-1:0] prev_l_q, prev_r_q;
  logic                        out_valid_q;
  logic [wfs_pkg::DRIVE_W-1:0] out_l_q, out_r_q;

  wfs_pkg::mdu_req_t mdu_req;
  wfs_pkg::mdu_rsp_t mdu_rsp;

  logic [SB-1:0]               ls_in, rs_in, cur_u;
  logic                        s_fire, m_fire, out_load;
  wfs_pkg::seg_t               seg;
  logic signed [wfs_pkg::RANGE_W:0] d;
  logic [wfs_pkg::RANGE_W-1:0] d_mag;
  logic [wfs_pkg::DIVR_W-1:0]  div_eff;
  logic [wfs_pkg::OPA_W-1:0]   q_mag, two_v, lim;
  logic signed [wfs_pkg::TGT_W-1:0] v_s, t_s;
  logic signed [wfs_pkg::TGT_W:0]   diff_l, diff_r;
  logic [wfs_pkg::TGT_W-1:0]   mag_l, mag_r;
  logic [wfs_pkg::SMOOTH_STEP_W-1:0] step;
  logic                        in_idle, in_out;

  assign ls_in  = s_axis_tdata[2*SB +: SB];
  assign rs_in  = s_axis_tdata[3*SB +: SB];
  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign m_fire = m_axis_tvalid && m_axis_tready;

  // Register writes: always ready, unknown indexes dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_speed_q <= wfs_pkg::RST_FULL_SPEED;
      slow_speed_q <= wfs_pkg::RST_SLOW_SPEED;
      slow_thr_q   <= wfs_pkg::RST_SLOW_THRESH;
      stop_thr_q   <= wfs_pkg::RST_STOP_THRESH;
      steer_div_q  <= wfs_pkg::RST_STEER_DIVIDER;
      stop_left_q  <= wfs_pkg::RST_STOP_LEFT;
      stop_right_q <= wfs_pkg::RST_STOP_RIGHT;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        wfs_pkg::CFG_FULL_SPEED:    full_speed_q <= cfg_data_i[wfs_pkg::SPEED_W-1:0];
        wfs_pkg::CFG_SLOW_SPEED:    slow_speed_q <= cfg_data_i[wfs_pkg::SPEED_W-1:0];
        wfs_pkg::CFG_SLOW_THRESH:   slow_thr_q   <= cfg_data_i[wfs_pkg::THR_W-1:0];
        wfs_pkg::CFG_STOP_THRESH:   stop_thr_q   <= cfg_data_i[wfs_pkg::THR_W-1:0];
        wfs_pkg::CFG_STEER_DIVIDER: steer_div_q  <= cfg_data_i[wfs_pkg::DIVR_W-1:0];
        wfs_pkg::CFG_STOP_LEFT:     stop_left_q  <= cfg_data_i[wfs_pkg::DRIVE_W-1:0];
        wfs_pkg::CFG_STOP_RIGHT:    stop_right_q <= cfg_data_i[wfs_pkg::DRIVE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Shared datapath helpers
  assign cur_u   = side_q ? rf_q : lf_q;
  assign seg     = wfs_pkg::front_seg(cur_u);
  assign d       = $signed({1'b0, rl_q}) - $signed({1'b0, rr_q});
  assign d_mag   = d[wfs_pkg::RANGE_W] ? wfs_pkg::RANGE_W'(-d) : d[wfs_pkg::RANGE_W-1:0];
  assign div_eff = (steer_div_q == '0) ? wfs_pkg::DIVR_W'(1) : steer_div_q;
  assign q_mag   = mdu_rsp.result[wfs_pkg::OPA_W-1:0];
  assign two_v   = wfs_pkg::OPA_W'({v_q, 1'b0});
  assign lim     = (q_mag < two_v) ? q_mag : two_v;
  assign v_s     = $signed(wfs_pkg::TGT_W'(v_q));
  assign t_s     = v_s - $signed(wfs_pkg::TGT_W'(lim));
  assign diff_l  = $signed({prev_l_q[wfs_pkg::TGT_W-1], prev_l_q})
                 - $signed({tgt_l_q[wfs_pkg::TGT_W-1], tgt_l_q});
  assign diff_r  = $signed({prev_r_q[wfs_pkg::TGT_W-1], prev_r_q})
                 - $signed({tgt_r_q[wfs_pkg::TGT_W-1], tgt_r_q});
  assign mag_l   = diff_l[wfs_pkg::TGT_W-1:0];
  assign mag_r   = diff_r[wfs_pkg::TGT_W-1:0];
  assign step    = mdu_rsp.result[wfs_pkg::RECIP_10_SHIFT +: wfs_pkg::SMOOTH_STEP_W];

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      wfs_pkg::ST_IDLE:     if (s_fire) state_d = wfs_pkg::ST_RNG_MUL;
      wfs_pkg::ST_RNG_MUL:  state_d = wfs_pkg::ST_RNG_SUB;
      wfs_pkg::ST_RNG_SUB:  if (mdu_rsp.done) state_d = wfs_pkg::ST_RNG_REC;
      wfs_pkg::ST_RNG_REC:  state_d = wfs_pkg::ST_RNG_CAP;
      wfs_pkg::ST_RNG_CAP: begin
        if (mdu_rsp.done) state_d = side_q ? wfs_pkg::ST_STR_MUL : wfs_pkg::ST_RNG_MUL;
      end
      wfs_pkg::ST_STR_MUL:  state_d = wfs_pkg::ST_STR_DIV;
      wfs_pkg::ST_STR_DIV:  if (mdu_rsp.done) state_d = wfs_pkg::ST_STR_WAIT;
      wfs_pkg::ST_STR_WAIT: if (mdu_rsp.done) state_d = wfs_pkg::ST_SML_MUL;
      wfs_pkg::ST_SML_MUL:  state_d = wfs_pkg::ST_SML_CAP;
      wfs_pkg::ST_SML_CAP:  if (mdu_rsp.done) state_d = wfs_pkg::ST_SMR_MUL;
      wfs_pkg::ST_SMR_MUL:  state_d = wfs_pkg::ST_SMR_CAP;
      wfs_pkg::ST_SMR_CAP:  if (mdu_rsp.done) state_d = wfs_pkg::ST_OUT;
      wfs_pkg::ST_OUT:      if (out_load) state_d = wfs_pkg::ST_IDLE;
      default:              state_d = wfs_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and requests to the shared unit
  always_comb begin
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    mdu_req.start = 1'b0;
    mdu_req.op    = wfs_pkg::MDU_MUL;
    mdu_req.a     = '0;
    mdu_req.b     = '0;
    case (state_q)
      wfs_pkg::ST_IDLE: s_axis_tready = 1'b1;
      wfs_pkg::ST_RNG_MUL: begin
        mdu_req.start = 1'b1;
        mdu_req.a     = wfs_pkg::OPA_W'(cur_u);
        mdu_req.b     = wfs_pkg::OPB_W'(seg.slope);
      end
      wfs_pkg::ST_RNG_REC: begin
        mdu_req.start = 1'b1;
        mdu_req.a     = num_q;
        mdu_req.b     = wfs_pkg::RECIP_1000;
      end
      wfs_pkg::ST_STR_MUL: begin
        mdu_req.start = 1'b1;
        mdu_req.a     = wfs_pkg::OPA_W'(d_mag);
        mdu_req.b     = wfs_pkg::OPB_W'(v_q);
      end
      wfs_pkg::ST_STR_DIV: begin
        mdu_req.start = mdu_rsp.done;
        mdu_req.op    = wfs_pkg::MDU_DIV;
        mdu_req.a     = mdu_rsp.result[wfs_pkg::OPA_W-1:0];
        mdu_req.b     = wfs_pkg::OPB_W'(div_eff);
      end
      wfs_pkg::ST_SML_MUL: begin
        mdu_req.start = 1'b1;
        mdu_req.a     = wfs_pkg::OPA_W'(mag_l);
        mdu_req.b     = wfs_pkg::RECIP_10;
      end
      wfs_pkg::ST_SMR_MUL: begin
        mdu_req.start = 1'b1;
        mdu_req.a     = wfs_pkg::OPA_W'(mag_r);
        mdu_req.b     = wfs_pkg::RECIP_10;
      end
      wfs_pkg::ST_OUT: out_load = !out_valid_q || m_axis_tready;
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  wfs_mdu u_mdu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mdu_req),
    .rsp_o  (mdu_rsp)
  );

  // Control state, smoothing memory and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wfs_pkg::ST_IDLE;
      side_q      <= 1'b0;
      out_valid_q <= 1'b0;
      prev_l_q    <= wfs_pkg::RST_PREV_DRIVE;
      prev_r_q    <= wfs_pkg::RST_PREV_DRIVE;
    end else begin
      state_q <= state_d;
      if (s_fire) begin
        side_q <= 1'b0;
      end else if (state_q == wfs_pkg::ST_RNG_CAP && mdu_rsp.done) begin
        side_q <= !side_q;
      end
      // Drops move a tenth of the way, rises are taken at once
      if (state_q == wfs_pkg::ST_SML_CAP && mdu_rsp.done) begin
        prev_l_q <= (tgt_l_q < prev_l_q)
                  ? prev_l_q - $signed(wfs_pkg::TGT_W'(step)) : tgt_l_q;
      end
      if (state_q == wfs_pkg::ST_SMR_CAP && mdu_rsp.done) begin
        prev_r_q <= (tgt_r_q < prev_r_q)
                  ? prev_r_q - $signed(wfs_pkg::TGT_W'(step)) : tgt_r_q;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working values
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      lf_q   <= s_axis_tdata[0 +: SB];
      rf_q   <= s_axis_tdata[SB +: SB];
      v_q    <= (ls_in > SB'(slow_thr_q) || rs_in > SB'(slow_thr_q))
              ? slow_speed_q : full_speed_q;
      stop_q <= ls_in > SB'(stop_thr_q) || rs_in > SB'(stop_thr_q);
    end
    if (state_q == wfs_pkg::ST_RNG_SUB && mdu_rsp.done) begin
      num_q <= wfs_pkg::OPA_W'(seg.icpt) - mdu_rsp.result[wfs_pkg::OPA_W-1:0];
    end
    if (state_q == wfs_pkg::ST_RNG_CAP && mdu_rsp.done) begin
      if (side_q) begin
        rr_q <= mdu_rsp.result[wfs_pkg::RECIP_1000_SHIFT +: wfs_pkg::RANGE_W];
      end else begin
        rl_q <= mdu_rsp.result[wfs_pkg::RECIP_1000_SHIFT +: wfs_pkg::RANGE_W];
      end
    end
    // Steer away from the nearer wall by slowing the outer wheel
    if (state_q == wfs_pkg::ST_STR_WAIT && mdu_rsp.done) begin
      if (d[wfs_pkg::RANGE_W]) begin
        tgt_l_q <= v_s;
        tgt_r_q <= t_s;
      end else begin
        tgt_l_q <= t_s;
        tgt_r_q <= v_s;
      end
    end
    if (out_load) begin
      out_l_q <= stop_q ? stop_left_q  : prev_l_q[wfs_pkg::DRIVE_W-1:0];
      out_r_q <= stop_q ? stop_right_q : prev_r_q[wfs_pkg::DRIVE_W-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_r_q, out_l_q};

  // Checks
  assign in_idle = state_q == wfs_pkg::ST_IDLE;
  assign in_out  = state_q == wfs_pkg::ST_OUT;

  `WFS_ASSERT(a_accept_starts, s_fire |=> state_q == wfs_pkg::ST_RNG_MUL, "word did not start")
  `WFS_ASSERT(a_out_from_seq, $rose(m_axis_tvalid) |-> $past(in_out), "word raised early")
  `WFS_ASSERT_NEVER(a_stray_done, mdu_rsp.done && (in_idle || in_out), "unexpected unit done")

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the wall follow steering unit: sample words go in
// over the slave stream, drive words are checked against an in-bench model of
// the range table, speed limit, steering clamp, smoothing and stop override.
// ----------------------------------------------------------------------------
module tb_top;
  import wfs_pkg::*;

  localparam int unsigned SB          = SAMPLE_BITS;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_WORDS = 110;
  localparam int unsigned TAIL_CYCLES = 100;
  localparam longint      TIMEOUT_NS  = 64'd20_000_000;

  typedef struct packed {
    logic [DRIVE_W-1:0] right;
    logic [DRIVE_W-1:0] left;
  } drive_word_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // Model copy of the registers and the smoothing memory
  logic [SPEED_W-1:0]        full_speed_q;
  logic [SPEED_W-1:0]        slow_speed_q;
  logic [THR_W-1:0]          slow_thr_q;
  logic [THR_W-1:0]          stop_thr_q;
  logic [DIVR_W-1:0]         steer_div_q;
  logic signed [DRIVE_W-1:0] stop_left_q;
  logic signed [DRIVE_W-1:0] stop_right_q;
  int                        last_left;
  int                        last_right;

  drive_word_t drive_queue[$];
  int          err_count;
  bit          no_idle;

  wall_follow_steering_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #(TIMEOUT_NS);
    $display("wall_follow_steering_unit verification failed");
    $finish;
  end

  // ---------------------------------------------------------------- model

  // Piecewise linear range of one front sample
  function automatic int front_range(input int u);
    if (u < 100) return 300;
    if (u < 164) return (330591 - 1041 * u) / 1000;
    if (u < 481) return (216775 - 347 * u) / 1000;
    if (u < 614) return (104231 - 112 * u) / 1000;
    return 35;
  endfunction

  // Ease drops by a tenth, take rises at once
  function automatic int ease_drive(input int target, input int prev);
    int diff;
    diff = target - prev;
    return (diff < 0) ? prev + diff / 10 : target;
  endfunction

  // Work out the drive word of one sample set and advance the memory
  function automatic drive_word_t predict_drives(input logic [SB-1:0] lf,
                                                 input logic [SB-1:0] rf,
                                                 input logic [SB-1:0] ls,
                                                 input logic [SB-1:0] rs);
    drive_word_t w;
    int d, v, dv, q, tl, tr;
    d  = front_range(int'(lf)) - front_range(int'(rf));
    v  = (ls > slow_thr_q || rs > slow_thr_q) ? int'(slow_speed_q) : int'(full_speed_q);
    dv = (steer_div_q == '0) ? 1 : int'(steer_div_q);
    q  = (d * v) / dv;
    if (d < 0) begin
      tl = v;
      tr = v + ((q > -2 * v) ? q : -2 * v);
    end else begin
      tr = v;
      tl = v - ((q < 2 * v) ? q : 2 * v);
    end
    last_left  = ease_drive(tl, last_left);
    last_right = ease_drive(tr, last_right);
    w.left  = DRIVE_W'(last_left);
    w.right = DRIVE_W'(last_right);
    // Stop override leaves the memory alone
    if (ls > stop_thr_q || rs > stop_thr_q) begin
      w.left  = stop_left_q;
      w.right = stop_right_q;
    end
    return w;
  endfunction

  // -------------------------------------------------------------- helpers

  task automatic flag_error(input string msg);
    if (err_count < 10) $display("%s", msg);
    err_count++;
  endtask

  function automatic int clip_sample(input int x);
    if (x < 0) return 0;
    if (x > (1 << SB) - 1) return (1 << SB) - 1;
    return x;
  endfunction

  // Mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Send one sample word and predict its drive word on acceptance
  task automatic send_samples(input logic [SB-1:0] lf, input logic [SB-1:0] rf,
                              input logic [SB-1:0] ls, input logic [SB-1:0] rs);
    int gap;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {rs, ls, rf, lf};
    do @(posedge clk_i); while (!s_axis_tready);
    drive_queue.push_back(predict_drives(lf, rf, ls, rs));
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Hold the sender until every drive word has come back
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (drive_queue.size() != 0) @(posedge clk_i);
  endtask

  // Write one register; only called while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_FULL_SPEED:    full_speed_q = val[SPEED_W-1:0];
      CFG_SLOW_SPEED:    slow_speed_q = val[SPEED_W-1:0];
      CFG_SLOW_THRESH:   slow_thr_q   = val[THR_W-1:0];
      CFG_STOP_THRESH:   stop_thr_q   = val[THR_W-1:0];
      CFG_STEER_DIVIDER: steer_div_q  = val[DIVR_W-1:0];
      CFG_STOP_LEFT:     stop_left_q  = val[DRIVE_W-1:0];
      CFG_STOP_RIGHT:    stop_right_q = val[DRIVE_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_all_regs(input logic [CFG_DATA_W-1:0] fs, input logic [CFG_DATA_W-1:0] ss,
                                input logic [CFG_DATA_W-1:0] st, input logic [CFG_DATA_W-1:0] pt,
                                input logic [CFG_DATA_W-1:0] dv, input logic [CFG_DATA_W-1:0] sl,
                                input logic [CFG_DATA_W-1:0] sr);
    write_reg(CFG_FULL_SPEED, fs);
    write_reg(CFG_SLOW_SPEED, ss);
    write_reg(CFG_SLOW_THRESH, st);
    write_reg(CFG_STOP_THRESH, pt);
    write_reg(CFG_STEER_DIVIDER, dv);
    write_reg(CFG_STOP_LEFT, sl);
    write_reg(CFG_STOP_RIGHT, sr);
  endtask

  // Front samples: uniform, or hugging a table breakpoint
  function automatic logic [SB-1:0] pick_front();
    int knees[10] = '{0, 99, 100, 163, 164, 480, 481, 613, 614, 1023};
    if ($urandom_range(0, 9) < 7) return SB'($urandom);
    return SB'(clip_sample(knees[$urandom_range(0, 9)] + $urandom_range(0, 2) - 1));
  endfunction

  // Side samples: at most the slow threshold, at most the stop threshold, near one of them, or uniform
  function automatic logic [SB-1:0] pick_side();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return SB'($urandom_range(0, int'(slow_thr_q)));
    if (r < 5) return SB'(clip_sample(int'(slow_thr_q) + $urandom_range(0, 2) - 1));
    if (r < 6) return SB'(clip_sample(int'(stop_thr_q) + $urandom_range(0, 2) - 1));
    if (r < 7) return SB'($urandom_range(0, int'(stop_thr_q)));
    return SB'($urandom);
  endfunction

  // ------------------------------------------------------------ receiver

  // Stall the drive stream at random, in runs
  initial begin
    int stall_left;
    int r;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (no_idle) begin
        m_axis_tready <= 1'b1;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          m_axis_tready <= 1'b1;
        end else begin
          m_axis_tready <= 1'b0;
          stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 60);
        end
      end
    end
  end

  // Compare each accepted drive word with the oldest prediction
  always @(posedge clk_i) begin
    drive_word_t got;
    drive_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (drive_queue.size() == 0) begin
        flag_error($sformatf("unexpected drive word left=%0d right=%0d",
                             $signed(got.left), $signed(got.right)));
      end else begin
        want = drive_queue.pop_front();
        if (got.left !== want.left || got.right !== want.right)
          flag_error($sformatf("drive mismatch: expected left=%0d right=%0d, got left=%0d right=%0d",
                               $signed(want.left), $signed(want.right),
                               $signed(got.left), $signed(got.right)));
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // Breakpoints of the range table at reset settings, sides clear
  task automatic test_front_table();
    send_samples(0, 1023, 0, 0);
    send_samples(1023, 0, 0, 0);
    send_samples(99, 100, 10, 20);
    send_samples(100, 99, 20, 10);
    send_samples(163, 164, 0, 0);
    send_samples(480, 481, 0, 0);
    send_samples(613, 614, 0, 0);
    send_samples(614, 1023, 0, 0);
    send_samples(512, 512, 0, 0);
  endtask

  // Slow and stop thresholds on each side, at and just past the value
  task automatic test_side_thresholds();
    send_samples(300, 150, 375, 375);
    send_samples(300, 150, 376, 0);
    send_samples(150, 300, 0, 376);
    send_samples(150, 300, 450, 450);
    send_samples(200, 600, 451, 0);
    send_samples(600, 200, 0, 1023);
    send_samples(200, 600, 0, 0);
  endtask

  // Register extremes, zero divider, excess value bits and a stray index
  task automatic test_register_extremes();
    wait_drained();
    write_all_regs(12'h7FF, 12'h000, 12'h000, 12'h3FF, 12'h000, 12'h800, 12'h7FF);
    send_samples(0, 1023, 0, 0);
    send_samples(1023, 0, 1, 0);
    send_samples(0, 1023, 1023, 1023);
    wait_drained();
    // Stray index must change nothing
    write_reg(CFG_UNUSED_IDX, 12'hFFF);
    send_samples(1023, 0, 0, 0);
    wait_drained();
    write_all_regs(12'hF00, 12'hFFF, 12'hFFF, 12'hC00, 12'hFFF, 12'h000, 12'h000);
    send_samples(0, 1023, 0, 0);
    send_samples(1023, 0, 0, 0);
    send_samples(300, 100, 0, 1);
    send_samples(100, 300, 1023, 1023);
  endtask

  // Random settings per phase, random sample sets in between
  task automatic test_random_phases();
    logic [CFG_DATA_W-1:0] fs, ss, st, pt, dv, sl, sr;
    int r;
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      no_idle = (ph == 3);
      fs = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom) : CFG_DATA_W'($urandom_range(0, 1024));
      ss = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom) : CFG_DATA_W'($urandom_range(0, 1024));
      st = CFG_DATA_W'($urandom_range(0, 1023));
      pt = ($urandom_range(0, 5) == 0) ? CFG_DATA_W'($urandom)
                                        : CFG_DATA_W'($urandom_range(int'(st), 1023));
      r = $urandom_range(0, 7);
      dv = (r == 0) ? 12'd0 : (r == 1) ? 12'd1 : (r == 2) ? 12'd1023
                                                          : CFG_DATA_W'($urandom_range(1, 400));
      sl = CFG_DATA_W'($urandom);
      sr = ($urandom_range(0, 1) == 0) ? CFG_DATA_W'($urandom)
                                       : CFG_DATA_W'(-$urandom_range(0, 1024));
      write_all_regs(fs, ss, st, pt, dv, sl, sr);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        // Hold the sender until the pipe is empty, now and then
        if ((ph == 0 && i == PHASE_WORDS / 2) || $urandom_range(0, 199) == 0) wait_drained();
        send_samples(pick_front(), pick_front(), pick_side(), pick_side());
      end
    end
    no_idle = 1'b0;
  endtask

  // ----------------------------------------------------------- main flow

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    no_idle       = 1'b0;
    err_count     = 0;
    full_speed_q  = RST_FULL_SPEED;
    slow_speed_q  = RST_SLOW_SPEED;
    slow_thr_q    = RST_SLOW_THRESH;
    stop_thr_q    = RST_STOP_THRESH;
    steer_div_q   = RST_STEER_DIVIDER;
    stop_left_q   = RST_STOP_LEFT;
    stop_right_q  = RST_STOP_RIGHT;
    last_left     = int'(RST_PREV_DRIVE);
    last_right    = int'(RST_PREV_DRIVE);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_front_table();
    test_side_thresholds();
    test_register_extremes();
    test_random_phases();

    // Drain, then watch for stray words
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (drive_queue.size() != 0)
      flag_error($sformatf("%0d drive words never arrived", drive_queue.size()));

    if (err_count == 0) begin
      $display("wall_follow_steering_unit verification clean");
    end else begin
      $display("wall_follow_steering_unit verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/wfs_pkg.sv
design/wfs_mdu.sv
design/wall_follow_steering_unit.sv
tb/tb_top.sv
